// File: rtl/lie_pkg.sv
`timescale 1ns / 1ps
package lie_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  localparam logic [StatusW-1:0] StatusOk  = 2'd0;
  localparam logic [StatusW-1:0] StatusSat = 2'd1;
  localparam logic [StatusW-1:0] StatusDup = 2'd2;

  localparam logic OpLoad = 1'b0;
  localparam logic OpEval = 1'b1;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StDupRd = 9'b000000010,
    StDupCk = 9'b000000100,
    StRdI   = 9'b000001000,
    StRdJ   = 9'b000010000,
    StDiv   = 9'b000100000,
    StMul   = 9'b001000000,
    StTerm  = 9'b010000000,
    StDone  = 9'b100000000
  } state_e;

endpackage

// File: rtl/lagrange_interpolation_eval_unit.sv
`timescale 1ns / 1ps
// Channel  | Direction | Signals                                              | Transfer
// ---------+-----------+------------------------------------------------------+------------------
// command  | in        | start_i, busy_o, op_i, node_index_i, node_abscissa_i,| start_i & !busy_o
//          |           | node_ordinate_i, eval_point_i                         |
// result   | out       | done_o, interp_value_o, status_o                      | done_o (one cycle)
// config   | in        | cfg_valid_i, cfg_ready_o, cfg_data_i                  | valid & ready
//
// An evaluation first scans all node pairs for duplicates, then for each i and each
// j != i runs one bit-serial divide and one multiply. Reset clears control and sets
// node_count to 1; the node memories are not cleared. The result receiver cannot stall.
module lagrange_interpolation_eval_unit #(
  parameter int unsigned MAX_NODES = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              op_i,
  input  logic [3:0]                        node_index_i,
  input  logic signed [lie_pkg::WordW-1:0]  node_abscissa_i,
  input  logic signed [lie_pkg::WordW-1:0]  node_ordinate_i,
  input  logic signed [lie_pkg::WordW-1:0]  eval_point_i,
  output logic                              done_o,
  output logic signed [lie_pkg::WordW-1:0]  interp_value_o,
  output logic [lie_pkg::StatusW-1:0]       status_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lie_pkg::CountW-1:0]        cfg_data_i
);

  localparam int unsigned AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW   = $clog2(MAX_NODES + 1);
  localparam int unsigned NW   = FRAC_BITS + 34;          // shifted numerator width
  localparam int unsigned DIVN = NW + 1;                  // setup plus one step per bit
  localparam int unsigned DCW  = $clog2(DIVN + 1);
  localparam int unsigned ACW  = 64 + AW;
  localparam logic [63:0] PosLim = 64'h7FFF_FFFF;
  localparam logic [63:0] NegLim = 64'h8000_0000;

  logic [lie_pkg::WordW-1:0] xmem [MAX_NODES];
  logic [lie_pkg::WordW-1:0] ymem [MAX_NODES];
  logic [lie_pkg::WordW-1:0] xrd_q, yrd_q;
  logic [AW-1:0]             raddr;

  lie_pkg::state_e state_q, state_d;
  logic [lie_pkg::CountW-1:0] cnt_q;
  logic [CW-1:0]  n_q, i_q, j_q;
  logic [CW-1:0]  jn;
  logic signed [31:0] x_q, xi_q, yi_q, p_q;
  logic           sat_q;
  logic signed [ACW-1:0] acc_q;
  logic           rd_j_q;
  logic           dup_q, status_d_dup;

  // divider
  logic [NW:0]    drem_q;
  logic [NW-1:0]  dnum_q;
  logic [NW-1:0]  dquo_q;
  logic [NW:0]    dden_q;
  logic [DCW-1:0] dcnt_q;
  logic           dneg_q;

  logic [31:0]    r_q;
  logic           rneg_q;

  logic [lie_pkg::CountW-1:0] limit;
  assign limit = (32'(cnt_q) > MAX_NODES) ? lie_pkg::CountW'(MAX_NODES) : cnt_q;

  assign jn = j_q + CW'(1);

  always_comb begin
    unique case (state_q)
      lie_pkg::StDupRd, lie_pkg::StDupCk: raddr = rd_j_q ? j_q[AW-1:0] : i_q[AW-1:0];
      lie_pkg::StRdI:                     raddr = i_q[AW-1:0];
      lie_pkg::StMul:                     raddr = jn[AW-1:0];
      lie_pkg::StRdJ:
        raddr = (!rd_j_q && j_q == i_q) ? jn[AW-1:0] : j_q[AW-1:0];
      default:                            raddr = j_q[AW-1:0];
    endcase
  end

  logic load_go;
  assign load_go = start_i && !busy_o && (op_i == lie_pkg::OpLoad)
                   && (32'(node_index_i) < MAX_NODES);

  always_ff @(posedge clk_i) begin
    if (load_go) begin
      xmem[AW'(node_index_i)] <= node_abscissa_i;
      ymem[AW'(node_index_i)] <= node_ordinate_i;
    end
    xrd_q <= xmem[raddr];
    yrd_q <= ymem[raddr];
  end

  assign busy_o      = (state_q != lie_pkg::StIdle);
  assign cfg_ready_o = !busy_o;

  // magnitudes
  function automatic logic [63:0] mag(input logic signed [63:0] v);
    mag = v[63] ? 64'(-v) : 64'(v);
  endfunction

  logic signed [32:0] num_s, den_s;
  assign num_s = 33'(x_q) - 33'($signed(xrd_q));
  assign den_s = 33'(xi_q) - 33'($signed(xrd_q));

  logic [63:0] pmag, ymag;
  assign pmag = mag(64'(p_q));
  assign ymag = mag(64'(yi_q));

  // multiply (one 32x32 per cycle)
  logic [31:0] ma, mb;
  logic        mneg;
  logic [63:0] mprod, mrnd;
  logic signed [63:0] msgn;
  logic        msat;
  always_comb begin
    if (state_q == lie_pkg::StMul) begin
      ma = pmag[31:0]; mb = r_q; mneg = p_q[31] ^ rneg_q;
    end else begin
      ma = ymag[31:0]; mb = pmag[31:0]; mneg = yi_q[31] ^ p_q[31];
    end
    mprod = 64'(ma) * 64'(mb);
    mrnd  = (mprod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    msat  = mneg ? (mrnd > NegLim) : (mrnd > PosLim);
    if (mneg) msgn = msat ? -$signed(NegLim) : -$signed(mrnd);
    else      msgn = msat ? $signed(PosLim) : $signed(mrnd);
  end

  logic [NW:0] dtry;
  assign dtry = {drem_q[NW-1:0], dnum_q[NW-1]} - dden_q;

  logic [63:0] qfin;
  logic        qsat;
  assign qfin = 64'(dquo_q);
  assign qsat = dneg_q ? (qfin > NegLim) : (qfin > PosLim);

  logic [63:0] amag;
  logic        aneg;
  assign aneg = acc_q[ACW-1];
  assign amag = aneg ? 64'(-acc_q) : 64'(acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lie_pkg::StIdle;
      cnt_q   <= 5'd1;
      done_o  <= 1'b0;
      interp_value_o <= '0;
      status_o <= lie_pkg::StatusOk;
    end else begin
      state_q <= state_d;
      done_o  <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) cnt_q <= cfg_data_i;
      unique case (state_q)
        lie_pkg::StIdle: begin
          if (start_i && op_i == lie_pkg::OpEval) begin
            n_q <= CW'(limit); i_q <= '0; j_q <= CW'(1); rd_j_q <= 1'b0;
            x_q <= eval_point_i; sat_q <= 1'b0; acc_q <= '0;
          end
        end
        lie_pkg::StDupRd: rd_j_q <= 1'b1;
        lie_pkg::StDupCk: begin
          if (rd_j_q) begin
            xi_q <= $signed(xrd_q); rd_j_q <= 1'b0;
          end else if (xrd_q == xi_q) begin
            rd_j_q <= 1'b0;
          end else if (j_q + 1'b1 < n_q) begin
            j_q <= j_q + 1'b1; rd_j_q <= 1'b0;
          end else if (i_q + CW'(2) < n_q) begin
            i_q <= i_q + 1'b1; j_q <= i_q + CW'(2);
          end else begin
            i_q <= '0;
          end
        end
        lie_pkg::StRdI: begin
          j_q <= '0; p_q <= 32'sd1 <<< FRAC_BITS; rd_j_q <= 1'b1;
        end
        lie_pkg::StRdJ: begin
          if (rd_j_q) begin
            xi_q <= $signed(xrd_q); yi_q <= $signed(yrd_q); rd_j_q <= 1'b0;
          end else if (j_q != i_q) begin
            dnum_q <= NW'({mag(64'(num_s)), 1'b0} << FRAC_BITS);
            dden_q <= (NW+1)'(mag(64'(den_s)));
            drem_q <= (NW+1)'(mag(64'(den_s)));
            dneg_q <= num_s[32] ^ den_s[32];
            dquo_q <= '0; dcnt_q <= '0;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        lie_pkg::StDiv: begin
          if (dcnt_q == DCW'(DIVN)) begin
            r_q <= qsat ? (dneg_q ? NegLim[31:0] : PosLim[31:0]) : qfin[31:0];
            rneg_q <= dneg_q; sat_q <= sat_q | qsat;
          end else begin
            // first step: rem holds d (rounding term = d over 2d divisor)
            if (dcnt_q == '0) begin
              dden_q <= {dden_q[NW-1:0], 1'b0};
              drem_q <= '0;
              dnum_q <= dnum_q + NW'(drem_q);
              dcnt_q <= dcnt_q + 1'b1;
            end else begin
              dnum_q <= {dnum_q[NW-2:0], 1'b0};
              if (!dtry[NW]) begin
                drem_q <= dtry; dquo_q <= {dquo_q[NW-2:0], 1'b1};
              end else begin
                drem_q <= {drem_q[NW-1:0], dnum_q[NW-1]}; dquo_q <= {dquo_q[NW-2:0], 1'b0};
              end
              dcnt_q <= dcnt_q + 1'b1;
            end
          end
        end
        lie_pkg::StMul: begin
          p_q <= msgn[31:0]; sat_q <= sat_q | msat; j_q <= j_q + 1'b1;
        end
        lie_pkg::StTerm: begin
          acc_q <= acc_q + ACW'(msgn); sat_q <= sat_q | msat;
          i_q <= i_q + 1'b1;
        end
        lie_pkg::StDone: begin
          done_o <= 1'b1;
          if (status_d_dup) begin
            interp_value_o <= '0; status_o <= lie_pkg::StatusDup;
          end else begin
            interp_value_o <= aneg ? ((amag > NegLim) ? NegLim[31:0] : 32'(-amag))
                                   : ((amag > PosLim) ? PosLim[31:0] : amag[31:0]);
            status_o <= (sat_q || (aneg ? amag > NegLim : amag > PosLim))
                        ? lie_pkg::StatusSat : lie_pkg::StatusOk;
          end
        end
        default: ;
      endcase
    end
  end

  assign status_d_dup = dup_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dup_q <= 1'b0;
    else if (state_q == lie_pkg::StIdle) dup_q <= 1'b0;
    else if (state_q == lie_pkg::StDupCk && !rd_j_q && xrd_q == xi_q) dup_q <= 1'b1;
  end

  // Divider entry trick: dcnt 0 adds d to 2n<<F and doubles d, giving (2n<<F + d)/(2d).
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lie_pkg::StIdle:
        if (start_i && op_i == lie_pkg::OpEval)
          state_d = (limit > 5'd1) ? lie_pkg::StDupRd : lie_pkg::StRdI;
      lie_pkg::StDupRd: state_d = lie_pkg::StDupCk;
      lie_pkg::StDupCk: begin
        if (rd_j_q) state_d = lie_pkg::StDupCk;
        else if (xrd_q == xi_q) state_d = lie_pkg::StDone;
        else if (j_q + 1'b1 < n_q) state_d = lie_pkg::StDupRd;
        else if (i_q + CW'(2) < n_q) state_d = lie_pkg::StDupRd;
        else state_d = lie_pkg::StRdI;
      end
      lie_pkg::StRdI: state_d = (i_q < n_q) ? lie_pkg::StRdJ : lie_pkg::StDone;
      lie_pkg::StRdJ: begin
        if (rd_j_q) state_d = lie_pkg::StRdJ;
        else if (j_q >= n_q) state_d = lie_pkg::StTerm;
        else if (j_q != i_q) state_d = lie_pkg::StDiv;
        else state_d = lie_pkg::StRdJ;
      end
      lie_pkg::StDiv: if (dcnt_q == DCW'(DIVN)) state_d = lie_pkg::StMul;
      lie_pkg::StMul: state_d = lie_pkg::StRdJ;
      lie_pkg::StTerm: state_d = lie_pkg::StRdI;
      lie_pkg::StDone: state_d = lie_pkg::StIdle;
      default: state_d = lie_pkg::StIdle;
    endcase
  end

`ifndef ASSERT_OFF
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done pulse too long");
  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == lie_pkg::StDone) else $error("done outside StDone");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy_o) else $error("config while busy");
`endif

endmodule
